// File: rtl/kcl_pkg.sv
// Shared types, codes and constants of the keypad combination lock.
package kcl_pkg;

  // Code storage depth and derived widths
  localparam int unsigned CODE_LEN = 7;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned LEN_W    = $clog2(CODE_LEN + 1);

  // Field widths of the result
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned EVT_W    = 3;
  localparam int unsigned TRIALS_W = 4;
  localparam int unsigned SHOWN_W  = 3;

  // Configuration port
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // Key meaning "no press"
  localparam logic [KEY_W-1:0] NO_KEY = 8'hFF;

  // Register reset values
  localparam logic [TRIALS_W-1:0] MAX_TRIALS_RST = 4'd3;
  localparam logic [KEY_W-1:0]    ENTER_KEY_RST  = 8'd46;
  localparam logic [KEY_W-1:0]    CLEAR_KEY_RST  = 8'd43;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 2'd0,
    MODE_LOCKED = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_e;

  typedef enum logic [EVT_W-1:0] {
    EV_IGNORED   = 3'd0,
    EV_KEY_TAKEN = 3'd1,
    EV_CODE_SET  = 3'd2,
    EV_UNLOCKED  = 3'd3,
    EV_WRONG     = 3'd4,
    EV_LOCKED    = 3'd5,
    EV_CLEARED   = 3'd6
  } evt_e;

  typedef enum logic [1:0] {
    REG_MAX_TRIALS = 2'd0,
    REG_ENTER_KEY  = 2'd1,
    REG_CLEAR_KEY  = 2'd2
  } reg_idx_e;

  // Register file contents seen by the lock
  typedef struct packed {
    logic [TRIALS_W-1:0] max_trials;
    logic [KEY_W-1:0]    enter_key;
    logic [KEY_W-1:0]    clear_key;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [MODE_W-1:0]   mode_now;
    logic [EVT_W-1:0]    event_res;
    logic [TRIALS_W-1:0] trials_left;
    logic                alarm_on;
    logic [SHOWN_W-1:0]  keys_entered;
    logic                bolt_open;
  } res_t;

  typedef logic [CODE_LEN-1:0][KEY_W-1:0] code_t;

endpackage

// File: rtl/kcl_ifs.sv
// Valid/ready channel interfaces for keypresses and lock results.
interface kcl_key_if import kcl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

interface kcl_res_if import kcl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode_now;
  logic [EVT_W-1:0]    event_res;
  logic [TRIALS_W-1:0] trials_left;
  logic                alarm_on;
  logic [SHOWN_W-1:0]  keys_entered;
  logic                bolt_open;

  modport source (
    output valid, output mode_now, output event_res, output trials_left,
    output alarm_on, output keys_entered, output bolt_open, input ready
  );
  modport sink (
    input valid, input mode_now, input event_res, input trials_left,
    input alarm_on, input keys_entered, input bolt_open, output ready
  );
endinterface

// File: rtl/keypad_combination_lock_top.sv
// Top level of the keypad combination lock: input stage, lock state, result register.
//
//   channel   dir  fields                                            flow
//   key_in    in   key_code                                          valid/ready
//   res_out   out  mode_now event_res trials_left alarm_on           valid/ready
//                  keys_entered bolt_open
//   apb       in   paddr pwdata -> prdata                            psel/penable, pready=1
//
// One keypress per cycle while the output is not stalled: a key waits in the
// input register, its lock update and compare of the seven-byte code run
// combinationally from there, and the result lands in the output register. A
// stalled output holds the result and backs up the input stage.
// Reset empties the stored code and entry and opens in code-setting mode.
module keypad_combination_lock_top import kcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  kcl_key_if.sink           key_in,
  kcl_res_if.source         res_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  kcl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control
  logic             in_valid_q;
  logic [KEY_W-1:0] key_q;
  logic             out_valid_q;
  res_t             res_q;
  logic             advance;

  // Lock state
  code_t               stored_q, stored_d;
  logic [LEN_W-1:0]    stored_len_q, stored_len_d;
  code_t               entry_q, entry_d;
  logic [LEN_W-1:0]    entry_len_q, entry_len_d;
  mode_e               mode_q, mode_d;
  logic [TRIALS_W-1:0] trials_q, trials_d;
  logic                alarm_q, alarm_d;
  evt_e                evt;
  res_t                res_d;

  assign advance      = in_valid_q & (~out_valid_q | res_out.ready);
  assign key_in.ready = ~in_valid_q | advance;

  // Hold the accepted key until the lock step takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (key_in.ready) begin
      in_valid_q <= key_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_in.valid && key_in.ready) begin
      key_q <= key_in.key_code;
    end
  end

  // Next lock state for the key in the input register
  always_comb begin
    stored_d     = stored_q;
    stored_len_d = stored_len_q;
    entry_d      = entry_q;
    entry_len_d  = entry_len_q;
    mode_d       = mode_q;
    trials_d     = trials_q;
    alarm_d      = alarm_q;
    evt          = EV_IGNORED;
    if (key_q != NO_KEY) begin
      if (mode_q == MODE_OPEN) begin
        if (key_q == cfg.clear_key) begin
          stored_d     = '1;
          stored_len_d = '0;
          entry_d      = '1;
          entry_len_d  = '0;
          mode_d       = MODE_SET;
          evt          = EV_CLEARED;
        end else if (key_q == cfg.enter_key) begin
          entry_d     = '1;
          entry_len_d = '0;
          mode_d      = MODE_LOCKED;
          evt         = EV_LOCKED;
        end
      end else if (key_q == cfg.enter_key && entry_len_q != '0) begin
        if (mode_q == MODE_SET) begin
          stored_d     = entry_q;
          stored_len_d = entry_len_q;
          mode_d       = MODE_OPEN;
          alarm_d      = 1'b0;
          trials_d     = cfg.max_trials;
          evt          = EV_CODE_SET;
        end else if (stored_q == entry_q) begin
          mode_d   = MODE_OPEN;
          alarm_d  = 1'b0;
          trials_d = cfg.max_trials;
          evt      = EV_UNLOCKED;
        end else begin
          trials_d = (trials_q != '0) ? trials_q - TRIALS_W'(1) : '0;
          if (trials_d == '0) begin
            alarm_d = 1'b1;
          end
          evt = EV_WRONG;
        end
        entry_d     = '1;
        entry_len_d = '0;
      end else if (32'(entry_len_q) < CODE_LEN) begin
        // Append the key at the current fill position
        for (int unsigned i = 0; i < CODE_LEN; i++) begin
          if (32'(entry_len_q) == i) begin
            entry_d[i] = key_q;
          end
        end
        entry_len_d = entry_len_q + LEN_W'(1);
        evt         = EV_KEY_TAKEN;
      end
    end
  end

  // Result for the key in the input register
  always_comb begin
    res_d.mode_now     = mode_d;
    res_d.event_res    = evt;
    res_d.trials_left  = trials_d;
    res_d.alarm_on     = alarm_d;
    res_d.keys_entered = (32'(entry_len_d) > 32'd7) ? SHOWN_W'(7) : SHOWN_W'(entry_len_d);
    res_d.bolt_open    = (mode_d != MODE_LOCKED);
  end

  // Advance lock state on each processed key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q     <= '1;
      stored_len_q <= '0;
      entry_q      <= '1;
      entry_len_q  <= '0;
      mode_q       <= MODE_SET;
      trials_q     <= MAX_TRIALS_RST;
      alarm_q      <= 1'b0;
    end else if (advance) begin
      stored_q     <= stored_d;
      stored_len_q <= stored_len_d;
      entry_q      <= entry_d;
      entry_len_q  <= entry_len_d;
      mode_q       <= mode_d;
      trials_q     <= trials_d;
      alarm_q      <= alarm_d;
    end
  end

  // Result register: load on advance, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_out.valid        = out_valid_q;
  assign res_out.mode_now     = res_q.mode_now;
  assign res_out.event_res    = res_q.event_res;
  assign res_out.trials_left  = res_q.trials_left;
  assign res_out.alarm_on     = res_q.alarm_on;
  assign res_out.keys_entered = res_q.keys_entered;
  assign res_out.bolt_open    = res_q.bolt_open;

`ifndef NO_ASSERTIONS
  a_alarm_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q |-> trials_q == '0)
    else $error("alarm raised with trials left");

  a_code_when_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_SET |-> stored_len_q != '0)
    else $error("lock armed or open without a stored code");

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(entry_len_q) <= CODE_LEN)
    else $error("entry length beyond code length");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed key produced no result");

  a_bolt_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.bolt_open == (res_q.mode_now != MODE_LOCKED))
    else $error("bolt state disagrees with mode");
`endif

endmodule

// File: rtl/kcl_regs.sv
// APB configuration registers of the keypad combination lock.
module kcl_regs import kcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_trials <= MAX_TRIALS_RST;
      cfg_q.enter_key  <= ENTER_KEY_RST;
      cfg_q.clear_key  <= CLEAR_KEY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_TRIALS: cfg_q.max_trials <= pwdata[TRIALS_W-1:0];
        REG_ENTER_KEY:  cfg_q.enter_key  <= pwdata[KEY_W-1:0];
        REG_CLEAR_KEY:  cfg_q.clear_key  <= pwdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero beyond the list
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MAX_TRIALS: prdata = APB_DW'(cfg_q.max_trials);
      REG_ENTER_KEY:  prdata = APB_DW'(cfg_q.enter_key);
      REG_CLEAR_KEY:  prdata = APB_DW'(cfg_q.clear_key);
      default:        prdata = '0;
    endcase
  end

endmodule
